// File: rtl/g3pe_pkg.sv
package g3pe_pkg;

  localparam int unsigned CoordW      = 24;
  localparam int unsigned DiffW       = CoordW + 1;
  localparam int unsigned SqW         = 2 * CoordW + 1;
  localparam int unsigned RxyW        = SqW + 1;
  localparam int unsigned CapBit      = 40;
  localparam int unsigned HalfW       = CapBit / 2;
  localparam int unsigned TermW       = CapBit + 1;
  localparam int unsigned FracW       = 32;
  localparam int unsigned AccW        = FracW + 2;
  localparam int unsigned ResW        = FracW + 1;
  localparam int unsigned NW          = 4;
  localparam int unsigned TaylorTerms = 14;
  localparam int unsigned ExpSteps    = 15;
  localparam int unsigned WeightW     = 16;
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [TermW-1:0]  TermCap  = TermW'(1) << CapBit;
  localparam logic [30:0]       ExpM1Q32 = 31'd1580030169;
  localparam logic [CoordW-1:0] InvReset = 24'h010000;

  typedef enum logic [CfgIdxW-1:0] {
    RegCenterX = 3'd0,
    RegCenterY = 3'd1,
    RegCenterZ = 3'd2,
    RegInvLat  = 3'd3,
    RegInvAx   = 3'd4
  } g3pe_reg_e;

  typedef struct packed {
    logic          last;
    logic          flush;
    logic [NW-1:0] n;
  } g3pe_side_t;

endpackage

// File: rtl/g3pe_in_if.sv
interface g3pe_in_if import g3pe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic                     last_point;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output last_point, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input last_point, output ready);
endinterface

// File: rtl/g3pe_out_if.sv
interface g3pe_out_if import g3pe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WeightW-1:0] weight;
  logic               last_result;

  modport source (output valid, output weight, output last_result, input ready);
  modport sink (input valid, input weight, input last_result, output ready);
endinterface

// File: rtl/g3pe_quad.sv
module g3pe_quad import g3pe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic                     last_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  logic        [CoordW-1:0] inv_lat_i,
  input  logic        [CoordW-1:0] inv_ax_i,
  output logic                     valid_o,
  output logic        [FracW-1:0]  frac_o,
  output g3pe_side_t               side_o
);

  localparam int unsigned Stages = 6;
  localparam int unsigned PartW  = HalfW + CoordW;
  localparam int unsigned ProdW  = CapBit + CoordW;
  localparam int unsigned SumW   = TermW + 1;

  function automatic logic [TermW-1:0] cap_term(logic [PartW-1:0] hi, logic [PartW-1:0] lo,
                                                logic big, logic zero);
    logic [ProdW-1:0] full;
    full = {hi, {HalfW{1'b0}}} + ProdW'(lo);
    if (zero) begin
      cap_term = '0;
    end else if (big || (full > ProdW'(TermCap))) begin
      cap_term = TermCap;
    end else begin
      cap_term = full[TermW-1:0];
    end
  endfunction

  logic [Stages-1:0] valid_q, valid_d;
  logic [Stages-2:0] last_q, last_d;

  // stage 1: differences
  logic signed [DiffW-1:0] dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;
  // stage 2: squares
  logic signed [2*DiffW-1:0] px, py, pz;
  logic [SqW-1:0] sqx_d, sqy_d, sqz_d, sqx_q, sqy_q, sqz_q;
  // stage 3: radial sum and range flags
  logic [RxyW-1:0]   rxy_sum;
  logic [CapBit-1:0] rxy_d, rz_d, rxy_q, rz_q;
  logic              bigxy3_d, bigz3_d, bigxy3_q, bigz3_q;
  // stage 4: partial products
  logic [PartW-1:0] phxy_d, plxy_d, phz_d, plz_d, phxy_q, plxy_q, phz_q, plz_q;
  logic             bigxy4_q, bigz4_q;
  // stage 5: capped terms
  logic [TermW-1:0] txy_d, tz_d, txy_q, tz_q;
  // stage 6: exponent split
  logic [SumW-1:0]  esum;
  logic [FracW-1:0] frac_d, frac_q;
  g3pe_side_t       side_d, side_q;

  assign valid_d = {valid_q[Stages-2:0], valid_i};
  assign last_d  = {last_q[Stages-3:0], last_i};

  assign dx_d = DiffW'(pos_x_i) - DiffW'(center_x_i);
  assign dy_d = DiffW'(pos_y_i) - DiffW'(center_y_i);
  assign dz_d = DiffW'(pos_z_i) - DiffW'(center_z_i);

  assign px    = dx_q * dx_q;
  assign py    = dy_q * dy_q;
  assign pz    = dz_q * dz_q;
  assign sqx_d = px[SqW-1:0];
  assign sqy_d = py[SqW-1:0];
  assign sqz_d = pz[SqW-1:0];

  assign rxy_sum  = RxyW'(sqx_q) + RxyW'(sqy_q);
  assign rxy_d    = rxy_sum[CapBit-1:0];
  assign bigxy3_d = |rxy_sum[RxyW-1:CapBit];
  assign rz_d     = sqz_q[CapBit-1:0];
  assign bigz3_d  = |sqz_q[SqW-1:CapBit];

  assign phxy_d = rxy_q[CapBit-1:HalfW] * inv_lat_i;
  assign plxy_d = rxy_q[HalfW-1:0] * inv_lat_i;
  assign phz_d  = rz_q[CapBit-1:HalfW] * inv_ax_i;
  assign plz_d  = rz_q[HalfW-1:0] * inv_ax_i;

  assign txy_d = cap_term(phxy_q, plxy_q, bigxy4_q, inv_lat_i == '0);
  assign tz_d  = cap_term(phz_q, plz_q, bigz4_q, inv_ax_i == '0);

  assign esum         = SumW'(txy_q) + SumW'(tz_q);
  assign frac_d       = esum[FracW:1];
  assign side_d.n     = esum[FracW+NW:FracW+1];
  assign side_d.flush = |esum[SumW-1:FracW+NW+1];
  assign side_d.last  = last_q[Stages-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q   <= last_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      dz_q     <= dz_d;
      sqx_q    <= sqx_d;
      sqy_q    <= sqy_d;
      sqz_q    <= sqz_d;
      rxy_q    <= rxy_d;
      rz_q     <= rz_d;
      bigxy3_q <= bigxy3_d;
      bigz3_q  <= bigz3_d;
      phxy_q   <= phxy_d;
      plxy_q   <= plxy_d;
      phz_q    <= phz_d;
      plz_q    <= plz_d;
      bigxy4_q <= bigxy3_q;
      bigz4_q  <= bigz3_q;
      txy_q    <= txy_d;
      tz_q     <= tz_d;
      frac_q   <= frac_d;
      side_q   <= side_d;
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign frac_o  = frac_q;
  assign side_o  = side_q;

endmodule

// File: rtl/g3pe_taylor.sv
module g3pe_taylor import g3pe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [FracW-1:0] frac_i,
  input  g3pe_side_t       side_i,
  output logic             valid_o,
  output logic [ResW-1:0]  res_o,
  output g3pe_side_t       side_o
);

  localparam int unsigned    Depth   = 2 * TaylorTerms;
  localparam logic [AccW-1:0] AccOne = AccW'(1) << FracW;
  localparam logic [ResW-1:0] ResOne = ResW'(1) << FracW;
  localparam bit             LastAdd = (TaylorTerms % 2) == 0;

  typedef struct packed {
    logic [FracW-1:0] f;
    logic [FracW-1:0] q;
    logic [AccW-1:0]  acc;
    g3pe_side_t       side;
  } mul_st_t;

  typedef struct packed {
    logic [FracW-1:0] f;
    logic [FracW-1:0] t;
    logic [AccW-1:0]  acc;
    g3pe_side_t       side;
  } div_st_t;

  logic [Depth-1:0] vld_q, vld_d;
  mul_st_t          mul_q [2:TaylorTerms];
  div_st_t          div_q [1:TaylorTerms];
  div_st_t          first_d;
  logic [AccW-1:0]  acc_last;
  logic [ResW-1:0]  res_d, res_q;
  g3pe_side_t       side_q;

  assign vld_d = {vld_q[Depth-2:0], valid_i};

  // first term is f itself
  always_comb begin
    first_d.f    = frac_i;
    first_d.t    = frac_i;
    first_d.acc  = AccOne;
    first_d.side = side_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[1] <= first_d;
    end
  end

  for (genvar k = 2; k <= TaylorTerms; k++) begin : g_term
    localparam int unsigned     K     = k;
    localparam int unsigned     L     = $clog2(K);
    localparam longint unsigned Num   = (64'd1 << (FracW + L)) + K - 1;
    localparam logic [FracW:0]  Recip = (FracW + 1)'(Num / K);
    localparam bit              Sub   = ((K - 1) % 2) == 1;

    logic [2*FracW-1:0] prod_a;
    logic [2*FracW:0]   prod_b;
    logic [2*FracW:0]   quo;
    mul_st_t            mul_d;
    div_st_t            div_d;

    always_comb begin
      prod_a     = div_q[k-1].t * div_q[k-1].f;
      mul_d.f    = div_q[k-1].f;
      mul_d.q    = prod_a[2*FracW-1:FracW];
      mul_d.acc  = Sub ? div_q[k-1].acc - AccW'(div_q[k-1].t)
                       : div_q[k-1].acc + AccW'(div_q[k-1].t);
      mul_d.side = div_q[k-1].side;
      // exact divide by k through reciprocal multiply
      prod_b     = mul_q[k].q * Recip;
      quo        = prod_b >> (FracW + L);
      div_d.f    = mul_q[k].f;
      div_d.t    = quo[FracW-1:0];
      div_d.acc  = mul_q[k].acc;
      div_d.side = mul_q[k].side;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mul_q[k] <= mul_d;
        div_q[k] <= div_d;
      end
    end
  end

  assign acc_last = LastAdd ? div_q[TaylorTerms].acc + AccW'(div_q[TaylorTerms].t)
                            : div_q[TaylorTerms].acc - AccW'(div_q[TaylorTerms].t);
  assign res_d    = acc_last[ResW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      side_q <= div_q[TaylorTerms].side;
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign res_o   = res_q;
  assign side_o  = side_q;

`ifndef SYNTHESIS
  a_series_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o <= ResOne))
    else $error("series result above one");
`endif

endmodule

// File: rtl/g3pe_scale.sv
module g3pe_scale import g3pe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [ResW-1:0]    res_i,
  input  g3pe_side_t         side_i,
  output logic               valid_o,
  output logic [WeightW-1:0] weight_o,
  output logic               last_o
);

  localparam int unsigned Depth  = ExpSteps + 1;
  localparam int unsigned ProdW  = ResW + $bits(ExpM1Q32);
  localparam int unsigned RoundW = ResW + 1;
  localparam int unsigned Drop   = FracW - WeightW;
  localparam int unsigned UpW    = RoundW - Drop;

  logic [Depth-1:0]   vld_q, vld_d;
  logic [ResW-1:0]    r_q [1:ExpSteps];
  g3pe_side_t         side_q [1:ExpSteps];
  logic [RoundW-1:0]  rnd;
  logic [UpW-1:0]     up;
  logic [WeightW-1:0] weight_d, weight_q;
  logic               last_q;

  assign vld_d = {vld_q[Depth-2:0], valid_i};

  for (genvar s = 1; s <= ExpSteps; s++) begin : g_step
    localparam logic [NW-1:0] Idx = NW'(s - 1);

    logic [ResW-1:0]  r_src, r_d;
    g3pe_side_t       side_src;
    logic [ProdW-1:0] prod;

    if (s == 1) begin : g_first
      assign r_src    = res_i;
      assign side_src = side_i;
    end else begin : g_next
      assign r_src    = r_q[s-1];
      assign side_src = side_q[s-1];
    end

    // one factor of exp(-1) per unit of the integer exponent
    always_comb begin
      prod = r_src * ExpM1Q32;
      r_d  = (Idx < side_src.n) ? ResW'(prod[ProdW-1:FracW]) : r_src;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]    <= r_d;
        side_q[s] <= side_src;
      end
    end
  end

  assign rnd = RoundW'(r_q[ExpSteps]) + (RoundW'(1) << (Drop - 1));
  assign up  = rnd[RoundW-1:Drop];

  always_comb begin
    if (side_q[ExpSteps].flush) begin
      weight_d = '0;
    end else if (|up[UpW-1:WeightW]) begin
      weight_d = '1;
    end else begin
      weight_d = up[WeightW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_q <= weight_d;
      last_q   <= side_q[ExpSteps].last;
    end
  end

  assign valid_o  = vld_q[Depth-1];
  assign weight_o = weight_q;
  assign last_o   = last_q;

endmodule

// File: rtl/gaussian_3d_point_evaluator_core.sv
// channel   | dir | payload                              | handshake
// ----------+-----+--------------------------------------+-------------
// in_i      | in  | pos_x, pos_y, pos_z, last_point      | valid/ready
// out_o     | out | weight, last_result                  | valid/ready
// cfg       | in  | cfg_idx_i, cfg_data_i                | cfg_we_i
//
// one item per cycle sustained while the skid is empty
// the multiplier chain has 6 distance stages, 28 series stages,
// 16 exponent scaling and rounding stages; the skid adds none when not stalled
// reset clears valid bits and skid, config goes to center 0 and unit widths
// a stalled item parks in a one-entry skid; the pipe holds while it is full
module gaussian_3d_point_evaluator_core import g3pe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  g3pe_in_if.sink             in_i,
  g3pe_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoordW-1:0]   cfg_data_i
);

  logic signed [CoordW-1:0] center_x_q, center_y_q, center_z_q;
  logic        [CoordW-1:0] inv_lat_q, inv_ax_q;

  logic               en;
  logic               quad_vld;
  logic [FracW-1:0]   quad_frac;
  g3pe_side_t         quad_side;
  logic               tay_vld;
  logic [ResW-1:0]    tay_res;
  g3pe_side_t         tay_side;
  logic               pipe_vld;
  logic [WeightW-1:0] pipe_weight;
  logic               pipe_last;

  logic               skid_vld_q, skid_vld_d;
  logic [WeightW-1:0] skid_weight_q;
  logic               skid_last_q;
  logic               skid_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      inv_lat_q  <= InvReset;
      inv_ax_q   <= InvReset;
    end else if (cfg_we_i) begin
      case (g3pe_reg_e'(cfg_idx_i))
        RegCenterX: center_x_q <= signed'(cfg_data_i);
        RegCenterY: center_y_q <= signed'(cfg_data_i);
        RegCenterZ: center_z_q <= signed'(cfg_data_i);
        RegInvLat:  inv_lat_q  <= cfg_data_i;
        RegInvAx:   inv_ax_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !skid_vld_q;
  assign in_i.ready = en;

  g3pe_quad u_quad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_i.valid && en),
    .pos_x_i    (in_i.pos_x),
    .pos_y_i    (in_i.pos_y),
    .pos_z_i    (in_i.pos_z),
    .last_i     (in_i.last_point),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .inv_lat_i  (inv_lat_q),
    .inv_ax_i   (inv_ax_q),
    .valid_o    (quad_vld),
    .frac_o     (quad_frac),
    .side_o     (quad_side)
  );

  g3pe_taylor u_taylor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quad_vld),
    .frac_i  (quad_frac),
    .side_i  (quad_side),
    .valid_o (tay_vld),
    .res_o   (tay_res),
    .side_o  (tay_side)
  );

  g3pe_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (tay_vld),
    .res_i    (tay_res),
    .side_i   (tay_side),
    .valid_o  (pipe_vld),
    .weight_o (pipe_weight),
    .last_o   (pipe_last)
  );

  assign out_o.valid       = skid_vld_q || pipe_vld;
  assign out_o.weight      = skid_vld_q ? skid_weight_q : pipe_weight;
  assign out_o.last_result = skid_vld_q ? skid_last_q : pipe_last;

  assign skid_load = !skid_vld_q && pipe_vld && !out_o.ready;

  always_comb begin
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (out_o.ready) begin
        skid_vld_d = 1'b0;
      end
    end else if (skid_load) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_load) begin
      skid_weight_q <= pipe_weight;
      skid_last_q   <= pipe_last;
    end
  end

`ifndef SYNTHESIS
  a_skid_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_o.valid)
    else $error("parked item not presented");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_o.valid && !out_o.ready))
    else $error("skid filled without a stall");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_o.ready) |=>
      (skid_vld_q && $stable(skid_weight_q) && $stable(skid_last_q)))
    else $error("parked item lost or changed");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import g3pe_pkg::*;

  localparam int unsigned CycLimit    = 1000000;
  localparam int unsigned DrainCyc    = 60;
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned PtsPerPhase = 205;
  localparam int unsigned MaxShown    = 10;

  localparam logic [CoordW-1:0] CoordMin = 24'h800000;
  localparam logic [CoordW-1:0] CoordMax = 24'h7fffff;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     last;
  } point_t;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic               last;
  } weight_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoordW-1:0]  cfg_data_i;

  g3pe_in_if  in_if();
  g3pe_out_if out_if();

  gaussian_3d_point_evaluator_core i_dut (
    .clk_i,
    .rst_ni,
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  logic signed [CoordW-1:0] ctr_x, ctr_y, ctr_z;
  logic [CoordW-1:0]        inv_lat, inv_ax;
  logic [CfgIdxW-1:0]       junk_idx;

  point_t      pend_pts[$];
  weight_t     want_q[$];
  point_t      cur_pt;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned miss_cnt;
  int unsigned cyc_cnt = 0;
  bit          gaps_on;
  bit          stalls_on;

  function automatic longint unsigned dist_sq(logic signed [CoordW-1:0] p,
                                              logic signed [CoordW-1:0] c);
    longint d;
    d = longint'(p) - longint'(c);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic longint unsigned scaled_term(longint unsigned r, logic [CoordW-1:0] inv);
    longint unsigned t;
    if (inv == 0) return 0;
    if (r >= TermCap) return TermCap;
    t = r * inv;
    return (t > TermCap) ? TermCap : t;
  endfunction

  function automatic longint unsigned exp_neg_q32(longint unsigned f);
    longint unsigned acc, t;
    acc = 64'd1 << FracW;
    t   = acc;
    for (int k = 1; k <= TaylorTerms; k++) begin
      t = ((t * f) >> FracW) / 64'(k);
      if (k % 2 == 1) acc -= t;
      else acc += t;
    end
    return acc;
  endfunction

  function automatic weight_t gauss_weight(point_t p);
    longint unsigned e, n, r, w;
    weight_t res;
    e = (scaled_term(dist_sq(p.x, ctr_x) + dist_sq(p.y, ctr_y), inv_lat) +
         scaled_term(dist_sq(p.z, ctr_z), inv_ax)) >> 1;
    n = e >> FracW;
    w = 0;
    if (n < (64'd1 << NW)) begin
      r = exp_neg_q32(e & 64'hffff_ffff);
      for (longint unsigned i = 0; i < n; i++) r = (r * ExpM1Q32) >> FracW;
      w = (r + (64'd1 << 15)) >> 16;
      if (w > 65535) w = 65535;
    end
    res.weight = w[WeightW-1:0];
    res.last   = p.last;
    return res;
  endfunction

  function automatic int unsigned pick_gap(bit en);
    int unsigned r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CoordW-1:0] near_offset(int unsigned sh);
    return CoordW'(int'($urandom_range(0, 2 << sh)) - (1 << sh));
  endfunction

  function automatic logic [CoordW-1:0] rand_center();
    case ($urandom_range(0, 5))
      0: return CoordMin;
      1: return CoordMax;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic logic [CoordW-1:0] rand_inv();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return CoordW'($urandom) >> $urandom_range(0, 23);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t      p;
    int unsigned base;
    if ($urandom_range(0, 9) == 0) begin
      p.x = CoordW'($urandom);
      p.y = CoordW'($urandom);
      p.z = CoordW'($urandom);
    end else begin
      base = $urandom_range(0, 13);
      p.x  = ctr_x + near_offset($urandom_range(0, base));
      p.y  = ctr_y + near_offset($urandom_range(0, base));
      p.z  = ctr_z + near_offset($urandom_range(0, base));
    end
    p.last = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  task automatic add_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                           logic [CoordW-1:0] z, logic last);
    pend_pts.push_back('{x: x, y: y, z: z, last: last});
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (g3pe_reg_e'(idx))
      RegCenterX: ctr_x   = data;
      RegCenterY: ctr_y   = data;
      RegCenterZ: ctr_z   = data;
      RegInvLat:  inv_lat = data;
      RegInvAx:   inv_ax  = data;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
                             logic [CoordW-1:0] cz, logic [CoordW-1:0] il,
                             logic [CoordW-1:0] ia);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegCenterZ, cz);
    write_reg(RegInvLat, il);
    write_reg(RegInvAx, ia);
    // unmapped index, must be ignored
    write_reg(junk_idx, CoordW'($urandom));
    junk_idx = (junk_idx == '1) ? CfgIdxW'(int'(RegInvAx) + 1) : junk_idx + 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pend_pts.size() != 0 || in_if.valid || want_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_miss(string what, weight_t want, weight_t got);
    if (miss_cnt < MaxShown)
      $display("%s: expected weight %0d last %0b, got weight %0d last %0b",
               what, want.weight, want.last, got.weight, got.last);
    miss_cnt++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) want_q.push_back(gauss_weight(cur_pt));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pend_pts.size() != 0) begin
          cur_pt = pend_pts.pop_front();
          in_if.valid      <= 1'b1;
          in_if.pos_x      <= cur_pt.x;
          in_if.pos_y      <= cur_pt.y;
          in_if.pos_z      <= cur_pt.z;
          in_if.last_point <= cur_pt.last;
          gap_left = pick_gap(gaps_on);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    weight_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.weight = out_if.weight;
        got.last   = out_if.last_result;
        if (want_q.size() == 0) begin
          note_miss("unexpected item", '0, got);
        end else begin
          want = want_q.pop_front();
          if (got !== want) note_miss("weight mismatch", want, got);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap(stalls_on);
      end
    end
  end

  initial begin
    while (cyc_cnt < CycLimit) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.pos_x      = '0;
    in_if.pos_y      = '0;
    in_if.pos_z      = '0;
    in_if.last_point = 1'b0;
    out_if.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    ctr_x            = '0;
    ctr_y            = '0;
    ctr_z            = '0;
    inv_lat          = InvReset;
    inv_ax           = InvReset;
    junk_idx         = CfgIdxW'(int'(RegInvAx) + 1);
    miss_cnt         = 0;
    gaps_on          = 1'b0;
    stalls_on        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: unit widths, center at origin
    add_point(0, 0, 0, 1'b0);
    add_point(0, 0, 0, 1'b1);
    add_point(1, 0, 0, 1'b0);
    add_point(256, 0, 0, 1'b0);
    add_point(0, -256, 0, 1'b0);
    add_point(0, 0, 512, 1'b1);
    add_point(1448, 0, 0, 1'b0);
    add_point(1449, 0, 0, 1'b0);
    add_point(CoordMax, CoordMax, CoordMax, 1'b1);
    add_point(CoordMin, CoordMin, CoordMin, 1'b0);
    add_point(CoordMax, CoordMin, 0, 1'b0);
    add_point(-1, 1, -1, 1'b1);
    wait_idle();

    // lateral axis ignored, axial at full scale
    load_config(CoordMin, CoordMax, 0, '0, '1);
    add_point(CoordMax, CoordMin, 0, 1'b0);
    add_point(0, 0, 1, 1'b1);
    add_point(0, 0, -256, 1'b0);
    add_point(CoordMin, CoordMax, 16, 1'b0);
    add_point(CoordMin, CoordMax, CoordMin, 1'b1);
    wait_idle();

    load_config(CoordMax, CoordMin, CoordMax, '0, '0);
    add_point(CoordMin, CoordMin, CoordMin, 1'b0);
    add_point(0, 0, 0, 1'b1);
    add_point(CoordMax, CoordMax, 0, 1'b0);
    wait_idle();

    load_config(0, 0, 0, '1, '0);
    add_point(1, 0, CoordMax, 1'b0);
    add_point(0, 1, CoordMin, 1'b1);
    add_point(2, -3, 0, 1'b0);
    wait_idle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      load_config(rand_center(), rand_center(), rand_center(), rand_inv(), rand_inv());
      for (int i = 0; i < PtsPerPhase; i++) pend_pts.push_back(rand_point());
      wait_idle();
    end

    repeat (DrainCyc) @(posedge clk_i);
    if (miss_cnt == 0 && want_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
